/* rtl/path_point_query_engine_defines.svh */
// Assertion macros for the path point query engine
`ifndef PATH_POINT_QUERY_ENGINE_DEFINES_SVH
`define PATH_POINT_QUERY_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define PPQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ppq check failed");
`define PPQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ppq check failed");
`else
`define PPQ_ASSERT_IMPL(label, clk, rst_n, a, c)
`define PPQ_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/ppq_pkg.sv */
`default_nettype none
package ppq_pkg;
    localparam int DEF_MAX_POINTS = 1024;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_EVAL    = 2'd2,
        OP_NEAREST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_SCAN,
        S_SCAN_W,
        S_WIN,
        S_WIN_W,
        S_PAIR,
        S_PAIR_W,
        S_DIV,
        S_MUL,
        S_FETCH,
        S_FETCH_W,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

/* rtl/path_point_query_engine.sv */
`default_nettype none
// One item at a time (busy); a next item can be accepted in the cycle after the
// strobe. Search and window scans read one point memory entry per state pair;
// the interpolation ratio comes from a bit-serial divider.
// Reset clears the point count; the point memories are not cleared.
// The result strobe lasts one cycle; the receiver cannot stall.
module path_point_query_engine
#(
    parameter int MAX_POINTS = ppq_pkg::DEF_MAX_POINTS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] s_value,
    input  wire logic signed [31:0] l_value,
    input  wire logic signed [31:0] dl_value,
    input  wire logic signed [31:0] ddl_value,
    input  wire logic signed [31:0] box_start_s,
    input  wire logic signed [31:0] box_end_s,
    input  wire logic signed [31:0] box_start_l,
    input  wire logic signed [31:0] box_end_l,
    output logic                    done,
    output logic signed [31:0]      out_s,
    output logic signed [31:0]      out_l,
    output logic signed [31:0]      out_dl,
    output logic signed [31:0]      out_ddl,
    output logic [30:0]             path_length,
    output logic [1:0]              status
);
    import ppq_pkg::*;
`include "path_point_query_engine_defines.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    // point memory: s, l, dl, ddl in one word
    logic [127:0] mem [MAX_POINTS];
    logic [127:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic         wr_en;
    logic         accept;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] lo_reg, best_reg;
    logic [1:0]    op_reg;
    logic signed [31:0] q_reg, bs_reg, be_reg, ls_reg, le_reg;
    logic signed [31:0] first_s_reg, last_s_reg;
    logic signed [31:0] s0_reg, l0_reg, dl0_reg, ddl0_reg;
    logic signed [31:0] l1_reg, dl1_reg, ddl1_reg;
    logic signed [32:0] best_d_reg;
    logic          have_reg;
    logic [1:0]    mul_reg;
    logic [31:0]   r_reg;
    logic signed [31:0] o_s_reg, o_l_reg, o_dl_reg, o_ddl_reg;
    logic [1:0]    st_reg;
    logic          done_reg;
    logic [30:0]   len_reg;
    logic          first_ph_reg;

    logic signed [31:0] rs, rl, rdl, rddl;
    assign rs   = rd_data[31:0];
    assign rl   = rd_data[63:32];
    assign rdl  = rd_data[95:64];
    assign rddl = rd_data[127:96];

    // item accepted only while idle and no result pending
    assign accept = start && !busy;

    logic          div_go, div_done;
    logic [31:0]   div_q;
    logic [32:0]   s_gap;
    logic [32:0]   q_gap;

    // divisor taken from the upper bracket point as it arrives from memory
    assign s_gap = 33'(rs) - 33'(s0_reg);
    assign q_gap = 33'(q_reg) - 33'(s0_reg);

    ppq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend ({q_gap[31:0], 30'd0}),
        .divisor  (s_gap),
        .done     (div_done),
        .quotient (div_q)
    );

    // interpolation: one 33x32 product per cycle
    logic signed [32:0] dx;
    logic signed [31:0] x0;
    logic signed [65:0] prod;
    logic [65:0]        mag;
    logic [35:0]        qv;
    always_comb
    begin
        case (mul_reg)
            2'd0:    begin x0 = l0_reg;   dx = 33'(l1_reg) - 33'(l0_reg); end
            2'd1:    begin x0 = dl0_reg;  dx = 33'(dl1_reg) - 33'(dl0_reg); end
            default: begin x0 = ddl0_reg; dx = 33'(ddl1_reg) - 33'(ddl0_reg); end
        endcase
        prod = 66'(dx) * $signed({34'd0, r_reg});
        mag  = prod[65] ? (66'd0 - prod) : prod;
        qv   = 36'((mag + 66'(1 << 29)) >> 30);
    end
    logic signed [31:0] interp_v;
    assign interp_v = prod[65] ? (x0 - qv[31:0]) : (x0 + qv[31:0]);

    // l distance for nearest
    logic in_band;
    logic signed [32:0] ldist;
    assign in_band = (rl >= ls_reg) && (rl <= le_reg);
    assign ldist   = (rl > le_reg) ? (33'(rl) - 33'(le_reg)) : (33'(ls_reg) - 33'(rl));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    case (op_t'(op))
                        OP_CLEAR:  state_next = S_DONE;
                        OP_APPEND: state_next = S_DONE;
                        OP_EVAL:   state_next = (cnt_reg < CW'(2)) ? S_DONE : S_SCAN;
                        default:   state_next = (cnt_reg == '0) ? S_DONE : S_SCAN;
                    endcase
                end
            S_SCAN:   state_next = (idx_reg == cnt_reg) ? S_PAIR : S_SCAN_W;
            S_SCAN_W: state_next = (rs >= ((op_reg == OP_EVAL) ? q_reg : bs_reg))
                                   ? S_PAIR : S_SCAN;
            S_PAIR:   state_next = S_PAIR_W;
            S_PAIR_W:
                if (op_reg == OP_NEAREST)
                    state_next = (lo_reg == cnt_reg) ? S_FETCH_W : S_WIN_W;
                else if (lo_reg == '0 || lo_reg == cnt_reg)
                    state_next = S_FETCH_W;
                else if (first_ph_reg)
                    state_next = S_PAIR_W;
                else
                    state_next = S_DIV;
            S_WIN:    state_next = S_WIN_W;
            S_WIN_W:
                if (idx_reg == cnt_reg || rs > be_reg || in_band)
                    state_next = S_FETCH;
                else
                    state_next = S_WIN;
            S_FETCH:  state_next = S_FETCH_W;
            S_FETCH_W: state_next = S_DONE;
            S_DIV:    state_next = div_done ? S_MUL : S_DIV;
            S_MUL:    state_next = (mul_reg == 2'd2) ? S_DONE : S_MUL;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory address and control
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        div_go  = 1'b0;
        case (state_reg)
            S_IDLE:   wr_en = accept && (op_t'(op) == OP_APPEND) && (cnt_reg < MAXC);
            S_PAIR:   rd_addr = AW'((lo_reg == cnt_reg) ? (cnt_reg - CW'(1)) :
                                    (lo_reg == '0) ? lo_reg : (lo_reg - CW'(1)));
            // past the end the last point stays on the read port
            S_PAIR_W: rd_addr = AW'((lo_reg == cnt_reg) ? (cnt_reg - CW'(1)) : lo_reg);
            S_FETCH:  rd_addr = (best_reg == cnt_reg) ? lo_reg[AW-1:0] : best_reg[AW-1:0];
            default:  rd_addr = idx_reg[AW-1:0];
        endcase
        if (state_reg == S_PAIR_W && op_reg == OP_EVAL && !first_ph_reg &&
            lo_reg != '0 && lo_reg != cnt_reg)
            div_go = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[AW-1:0]] <= {ddl_value, dl_value, l_value, s_value};
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            if (state_reg == S_IDLE && accept)
            begin
                if (op_t'(op) == OP_CLEAR)
                    cnt_reg <= '0;
                else if (wr_en)
                    cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    op_reg <= op;
                    q_reg <= s_value; bs_reg <= box_start_s; be_reg <= box_end_s;
                    ls_reg <= box_start_l; le_reg <= box_end_l;
                    idx_reg <= '0; have_reg <= 1'b0; mul_reg <= 2'd0;
                    o_s_reg <= '0; o_l_reg <= '0; o_dl_reg <= '0; o_ddl_reg <= '0;
                    st_reg <= ST_OK;
                    case (op_t'(op))
                        OP_CLEAR: ;
                        OP_APPEND:
                            if (cnt_reg >= MAXC)
                                st_reg <= ST_FULL;
                            else
                            begin
                                o_s_reg <= s_value; o_l_reg <= l_value;
                                o_dl_reg <= dl_value; o_ddl_reg <= ddl_value;
                                if (cnt_reg == '0) first_s_reg <= s_value;
                                last_s_reg <= s_value;
                            end
                        OP_EVAL:  if (cnt_reg < CW'(2)) st_reg <= ST_FEW;
                        default:  if (cnt_reg == '0) st_reg <= ST_EMPTY;
                    endcase
                end
            S_SCAN:
                if (idx_reg == cnt_reg)
                    lo_reg <= idx_reg;
            S_SCAN_W:
                if (rs >= ((op_reg == OP_EVAL) ? q_reg : bs_reg))
                    lo_reg <= idx_reg;
                else
                    idx_reg <= idx_reg + CW'(1);
            S_PAIR:
            begin
                first_ph_reg <= 1'b1;
                best_reg <= (lo_reg == cnt_reg) ? (cnt_reg - CW'(1)) : lo_reg;
                idx_reg  <= lo_reg;
            end
            S_PAIR_W:
            begin
                first_ph_reg <= 1'b0;
                if (first_ph_reg && op_reg == OP_EVAL)
                begin
                    s0_reg <= rs; l0_reg <= rl; dl0_reg <= rdl; ddl0_reg <= rddl;
                end
                else if (op_reg == OP_EVAL)
                begin
                    l1_reg <= rl; dl1_reg <= rdl; ddl1_reg <= rddl;
                end
                if (op_reg == OP_NEAREST && lo_reg != cnt_reg)
                    best_reg <= cnt_reg;
            end
            S_WIN_W:
                if (idx_reg != cnt_reg && rs <= be_reg)
                begin
                    if (in_band)
                        best_reg <= idx_reg;
                    else if (!have_reg || ldist < best_d_reg)
                    begin
                        best_d_reg <= ldist; best_reg <= idx_reg; have_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
            S_FETCH_W:
            begin
                o_s_reg <= rs; o_l_reg <= rl; o_dl_reg <= rdl; o_ddl_reg <= rddl;
            end
            S_DIV:
                if (div_done) r_reg <= div_q;
            S_MUL:
            begin
                o_s_reg <= q_reg;
                case (mul_reg)
                    2'd0:    o_l_reg <= interp_v;
                    2'd1:    o_dl_reg <= interp_v;
                    default: o_ddl_reg <= interp_v;
                endcase
                mul_reg <= mul_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // path length from first/last station
    logic signed [32:0] len_d;
    assign len_d = 33'(last_s_reg) - 33'(first_s_reg);
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            if (cnt_reg == '0 || len_d[32])
                len_reg <= '0;
            else if (len_d[31])
                len_reg <= '1;
            else
                len_reg <= len_d[30:0];
        end
    end

    // outputs
    always_comb
    begin
        busy        = (state_reg != S_IDLE) || done_reg;
        done        = done_reg;
        out_s       = o_s_reg;
        out_l       = o_l_reg;
        out_dl      = o_dl_reg;
        out_ddl     = o_ddl_reg;
        path_length = len_reg;
        status      = st_reg;
    end

    `PPQ_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= MAXC)
    `PPQ_ASSERT_NEXT(a_done_one, clk, rst_n, done_reg, !done_reg)
    `PPQ_ASSERT_IMPL(a_busy_done, clk, rst_n, done_reg, busy)
    `PPQ_ASSERT_IMPL(a_div_idle, clk, rst_n, div_go, state_reg == S_PAIR_W)
endmodule
`default_nettype wire

/* rtl/ppq_div.sv */
`default_nettype none
// Restoring divider: 62-bit dividend by 33-bit divisor, one quotient bit a cycle.
module ppq_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [61:0] dividend,
    input  wire logic [32:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [61:0] num_reg, num_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[32:0], num_reg[61]} - {1'b0, den_reg};
        if (go)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'd62;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[60:0], ~trial[33]};
            rem_next = trial[33] ? {rem_reg[32:0], num_reg[61]} : trial;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd1);
    // quotient fits 32 bits (ratio at most 1, so quotient at most 2^30)
    assign quotient = num_next[31:0];
endmodule
`default_nettype wire
